// ===== sv/mkts_pkg.sv =====
// ----------------------------------------------------------------------------
// mkts_pkg: shared types and constants of the multi-key top-K selector
// Entry layout, comparison settings, cell operation codes, register indexes.
// ----------------------------------------------------------------------------
package mkts_pkg;

	localparam int MAX_BEST = 16;
	localparam int NUM_KEYS = 4;
	localparam int KEY_W    = 32;
	localparam int TAG_W    = 16;
	localparam int IDX_W    = $clog2(MAX_BEST);
	localparam int FILL_W   = $clog2(MAX_BEST + 1);
	localparam int NK_W     = 3;
	localparam int RANK_W   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_BEST_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_KEYS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DESC_MASK  = 2'd2;

	// operation codes of an input transaction
	localparam logic OP_OFFER = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		key_t [NUM_KEYS-1:0] keys;
		logic [TAG_W-1:0]    tag;
	} entry_t;

	typedef struct packed {
		logic [NK_W-1:0]     nk;    // active key count, already clamped
		logic [NUM_KEYS-1:0] desc;  // 1: larger is better
	} cmp_cfg_t;

	typedef enum logic [1:0] {
		CELL_HOLD       = 2'd0,
		CELL_LOAD_NEW   = 2'd1,
		CELL_FROM_BELOW = 2'd2,
		CELL_FROM_ABOVE = 2'd3
	} cell_op_t;

endpackage

// ===== sv/multi_key_top_k_selector.sv =====
// ----------------------------------------------------------------------------
// multi_key_top_k_selector: keeps the best records of a group, sorted
// Row of cells holding up to MAX_BEST entries ranked on up to four keys.
// ----------------------------------------------------------------------------
// For an offer transaction, in the accept cycle every cell
// compares the offered keys with its own entry in parallel and registers
// whether the offer beats it; in the next cycle the chain control finds the
// insertion point from those bits and every cell loads the new record,
// takes its neighbor's entry or holds, all at once. A flush transaction
// is accepted and then streams the kept tags best first, one result
// transaction per cycle while out_ready stays high, the last one
// marked by last_flag; a flush of an empty store gives no result. in_ready
// is low while an offer is being placed or a flush is streaming. The
// configuration port is always ready; index 0 best_count, 1 num_keys,
// 2 key_descending_mask, other indexes are ignored. Entry contents have no
// reset; only entries below the fill count are ever read.
module multi_key_top_k_selector (
	input  logic                                clk,
	input  logic                                arst_n,
	// input transaction
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic signed [mkts_pkg::KEY_W-1:0]   key_0,
	input  logic signed [mkts_pkg::KEY_W-1:0]   key_1,
	input  logic signed [mkts_pkg::KEY_W-1:0]   key_2,
	input  logic signed [mkts_pkg::KEY_W-1:0]   key_3,
	input  logic [mkts_pkg::TAG_W-1:0]          record_tag,
	// result transaction
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mkts_pkg::TAG_W-1:0]          kept_tag,
	output logic [mkts_pkg::RANK_W-1:0]         rank,
	output logic                                last_flag,
	// configuration write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mkts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mkts_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int MB = mkts_pkg::MAX_BEST;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_UPD   = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q;

	// configuration registers
	logic [4:0] best_count_q;
	logic [2:0] num_keys_q;
	logic [3:0] desc_mask_q;

	logic [mkts_pkg::FILL_W-1:0] fill_q;
	logic [mkts_pkg::FILL_W-1:0] keep_limit;
	mkts_pkg::cmp_cfg_t          cmp_cfg;

	mkts_pkg::entry_t in_entry;
	mkts_pkg::entry_t new_entry_q;

	mkts_pkg::entry_t   cell_entry [MB];
	mkts_pkg::entry_t   below_entry [MB];
	mkts_pkg::entry_t   above_entry [MB];
	mkts_pkg::cell_op_t cell_op [MB];
	logic [MB-1:0]      beat;
	logic [MB-1:0]      beat_valid;
	logic [MB-1:0]      pre;       // offer beats this cell and every one below
	logic [MB-1:0]      pre_below;
	logic [MB-1:0]      pre_above;
	logic               full;

	logic                        in_acc;
	logic                        cmp_en;
	logic [mkts_pkg::FILL_W-1:0] cnt_q;
	logic [mkts_pkg::RANK_W-1:0] emit_q;
	logic                        out_load;
	logic [mkts_pkg::IDX_W-1:0]  rd_idx;

	logic                        out_valid_q;
	logic [mkts_pkg::TAG_W-1:0]  kept_tag_q;
	logic [mkts_pkg::RANK_W-1:0] rank_q;
	logic                        last_flag_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign cmp_en    = in_acc && (operation == mkts_pkg::OP_OFFER);

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_count_q <= 5'd1;
			num_keys_q   <= 3'd1;
			desc_mask_q  <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mkts_pkg::CFG_BEST_COUNT: best_count_q <= cfg_data[4:0];
				mkts_pkg::CFG_NUM_KEYS:   num_keys_q   <= cfg_data[2:0];
				mkts_pkg::CFG_DESC_MASK:  desc_mask_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// zero keeps one record, anything above the store size keeps them all
	always_comb begin
		if (best_count_q == 5'd0) begin
			keep_limit = mkts_pkg::FILL_W'(1);
		end else if (mkts_pkg::FILL_W'(best_count_q) > mkts_pkg::FILL_W'(MB)) begin
			keep_limit = mkts_pkg::FILL_W'(MB);
		end else begin
			keep_limit = mkts_pkg::FILL_W'(best_count_q);
		end
	end

	always_comb begin
		if (num_keys_q > mkts_pkg::NK_W'(mkts_pkg::NUM_KEYS)) begin
			cmp_cfg.nk = mkts_pkg::NK_W'(mkts_pkg::NUM_KEYS);
		end else begin
			cmp_cfg.nk = num_keys_q;
		end
		cmp_cfg.desc = desc_mask_q;
	end

	// offered record straight from the ports for the compare in the accept cycle
	always_comb begin
		in_entry.keys[0] = key_0;
		in_entry.keys[1] = key_1;
		in_entry.keys[2] = key_2;
		in_entry.keys[3] = key_3;
		in_entry.tag     = record_tag;
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			new_entry_q <= in_entry;
		end
	end

	// ---- chain control ----
	// position 0 holds the worst entry; the insertion point is the first
	// cell from the bottom that the offer does not beat (when full, the last one it beats)
	always_comb begin
		for (int i = 0; i < MB; i++) begin
			beat_valid[i] = beat[i] && (mkts_pkg::FILL_W'(i) < fill_q);
		end
	end

	for (genvar g = 0; g < MB; g++) begin : g_pre
		assign pre[g] = &beat_valid[g:0];
	end

	assign pre_below = {pre[MB-2:0], 1'b1};
	assign pre_above = {1'b0, pre[MB-1:1]};
	assign full      = (fill_q >= keep_limit);

	always_comb begin
		for (int i = 0; i < MB; i++) begin
			cell_op[i] = mkts_pkg::CELL_HOLD;
			if (state_q == ST_UPD) begin
				if (!full) begin
					// room left: entries at and above the slot move up
					if (pre[i]) begin
						cell_op[i] = mkts_pkg::CELL_HOLD;
					end else if (pre_below[i]) begin
						cell_op[i] = mkts_pkg::CELL_LOAD_NEW;
					end else begin
						cell_op[i] = mkts_pkg::CELL_FROM_BELOW;
					end
				end else if (pre[i]) begin
					// full: worst falls out, beaten entries move down
					if (pre_above[i]) begin
						cell_op[i] = mkts_pkg::CELL_FROM_ABOVE;
					end else begin
						cell_op[i] = mkts_pkg::CELL_LOAD_NEW;
					end
				end
			end
		end
	end

	// ---- the row of cells ----
	for (genvar g = 0; g < MB; g++) begin : g_cell
		if (g == 0) begin : g_lo
			assign below_entry[g] = '0;
		end else begin : g_mid_lo
			assign below_entry[g] = cell_entry[g-1];
		end
		if (g == MB - 1) begin : g_hi
			assign above_entry[g] = '0;
		end else begin : g_mid_hi
			assign above_entry[g] = cell_entry[g+1];
		end

		mkts_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.new_entry   ((state_q == ST_UPD) ? new_entry_q : in_entry),
			.cfg         (cmp_cfg),
			.cmp_en      (cmp_en),
			.op          (cell_op[g]),
			.below_entry (below_entry[g]),
			.above_entry (above_entry[g]),
			.entry       (cell_entry[g]),
			.beat        (beat[g])
		);
	end

	// ---- sequencing, fill count and flush stream ----
	assign out_load = (state_q == ST_FLUSH) && (!out_valid_q || out_ready);
	assign rd_idx   = mkts_pkg::IDX_W'(cnt_q - mkts_pkg::FILL_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			cnt_q   <= '0;
			emit_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (operation == mkts_pkg::OP_OFFER) begin
							state_q <= ST_UPD;
						end else if (fill_q != '0) begin
							state_q <= ST_FLUSH;
							cnt_q   <= fill_q;
							emit_q  <= '0;
							fill_q  <= '0;
						end
					end
				end
				ST_UPD: begin
					if (!full) begin
						fill_q <= fill_q + mkts_pkg::FILL_W'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					if (out_load) begin
						cnt_q  <= cnt_q - mkts_pkg::FILL_W'(1);
						emit_q <= emit_q + mkts_pkg::RANK_W'(1);
						if (cnt_q == mkts_pkg::FILL_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: holds a result while the block moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kept_tag_q  <= cell_entry[rd_idx].tag;
			rank_q      <= emit_q;
			last_flag_q <= (cnt_q == mkts_pkg::FILL_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign kept_tag  = kept_tag_q;
	assign rank      = rank_q;
	assign last_flag = last_flag_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= mkts_pkg::FILL_W'(MB))
		else $error("fill count above store size");

	a_upd_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |=> (fill_q == $past(fill_q)) ||
			(fill_q == $past(fill_q) + mkts_pkg::FILL_W'(1)))
		else $error("offer changed fill count by more than one");

	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (fill_q == '0) && (cnt_q != '0))
		else $error("flush stream with store not emptied");

	a_offer_upd: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_en |=> (state_q == ST_UPD) && !in_ready)
		else $error("accepted offer not placed next cycle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !out_load)
		else $error("result overwritten before it was taken");
`endif

endmodule

// ===== sv/mkts_cell.sv =====
// ----------------------------------------------------------------------------
// mkts_cell: one slot of the sorted store
// Holds one entry, compares it with an offered record and moves data to or
// from its neighbors as the chain control orders.
// ----------------------------------------------------------------------------
module mkts_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mkts_pkg::entry_t   new_entry,
	input  mkts_pkg::cmp_cfg_t cfg,
	input  logic               cmp_en,
	input  mkts_pkg::cell_op_t op,
	input  mkts_pkg::entry_t   below_entry,
	input  mkts_pkg::entry_t   above_entry,
	output mkts_pkg::entry_t   entry,
	output logic               beat
);

	mkts_pkg::entry_t entry_q;
	logic             beat_q;
	logic             beats_d;

	// lexicographic compare, first differing active key decides
	always_comb begin
		logic decided;
		mkts_pkg::key_t a;
		mkts_pkg::key_t b;
		decided = 1'b0;
		beats_d = 1'b0;
		for (int k = 0; k < mkts_pkg::NUM_KEYS; k++) begin
			a = new_entry.keys[k];
			b = entry_q.keys[k];
			if (!decided && (mkts_pkg::NK_W'(k) < cfg.nk) && (a != b)) begin
				decided = 1'b1;
				beats_d = cfg.desc[k] ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= 1'b0;
		end else if (cmp_en) begin
			beat_q <= beats_d;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			mkts_pkg::CELL_HOLD:       entry_q <= entry_q;
			mkts_pkg::CELL_LOAD_NEW:   entry_q <= new_entry;
			mkts_pkg::CELL_FROM_BELOW: entry_q <= below_entry;
			mkts_pkg::CELL_FROM_ABOVE: entry_q <= above_entry;
			default:                   entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;
	assign beat  = beat_q;

endmodule
